// File: design/sfd_pkg.sv
// Shared constants and types for the serial frame deframer.
// Depends on nothing; every other design file but sfd_if imports it.
`default_nettype none

package sfd_pkg;

	localparam int FRAME_DEPTH_DEF = 64;
	localparam int RESULT_CAP = 64;
	localparam int CNT_W = 6;

	localparam logic [7:0] HDR_FIRST = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'hAF;
	localparam logic [7:0] FUNC_END = 8'hF1;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd49;

	// Fixed positions of the header fields in the frame store.
	typedef enum logic [1:0] {
		SLOT_HDR1 = 2'd0,
		SLOT_HDR2 = 2'd1,
		SLOT_FUNC = 2'd2,
		SLOT_LEN = 2'd3
	} slot_t;

	typedef struct packed {
		logic store;
		logic payload_slot;
		slot_t fixed_slot;
		logic load_len;
		logic step_payload;
		logic start_emit;
		logic read;
	} sfd_cmd_t;

	typedef struct packed {
		logic hdr1;
		logic hdr2;
		logic func_ok;
		logic len_ok;
		logic rem_nonzero;
		logic rem_one;
		logic read_last;
	} sfd_sts_t;

endpackage

`default_nettype wire

// File: design/sfd_if.sv
// Valid/ready channel interfaces for received bytes and emitted frame bytes.
// Stand-alone; no package is needed.
`default_nettype none

interface rx_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface frame_byte_if;
	logic valid;
	logic ready;
	logic [7:0] frame_byte;
	logic frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// File: design/serial_frame_deframer.sv
// Serial frame deframer: finds AA AF framed packets in a received byte stream.
// Top level; uses sfd_pkg, sfd_if, sfd_ctrl and sfd_dp.
//
// Bytes arrive on the rx channel, one per transaction. A frame is 0xAA, 0xAF,
// a function byte from 0x01 to 0xF0, a length byte from 1 to the limit register
// (capped at 59), that many payload bytes and one check byte (not verified).
// A byte that breaks the pattern is dropped and the block hunts for 0xAA again.
// While hunting or collecting, the block takes one byte per cycle.
// Once the check byte is taken, the whole frame is read out of the frame
// store on the frame channel, header first, with frame_last on the check byte.
// After the check byte is taken, the block enters its emit state and registers the
// first byte, then one byte per cycle while the receiver is ready; the store has
// one read port, so rx ready stays low until the whole frame has been read out.
// When the receiver stalls, the current output byte holds and reading pauses.
// The last frame byte may still wait on the output while new bytes are taken.
// cfg_we writes the 6-bit payload length limit, which resets to 49.
// An asynchronous reset returns the block to hunting with no output pending.
`default_nettype none

module serial_frame_deframer
	import sfd_pkg::*;
#(
	parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata,
	rx_byte_if.sink rx,
	frame_byte_if.source frame
);

	sfd_cmd_t cmd;
	sfd_sts_t sts;

	sfd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rx.valid),
		.in_ready(rx.ready),
		.out_ready(frame.ready),
		.out_valid(frame.valid),
		.cmd(cmd),
		.sts(sts)
	);

	sfd_dp #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx_byte(rx.rx_byte),
		.cmd(cmd),
		.sts(sts),
		.frame_byte(frame.frame_byte),
		.frame_last(frame.frame_last)
	);

endmodule

`default_nettype wire

// File: design/sfd_ctrl.sv
// Frame hunting and emission state machine of the serial frame deframer.
// Uses sfd_pkg for the command and status structs.
`default_nettype none

module sfd_ctrl
	import sfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic out_ready,
	output logic out_valid,
	output sfd_cmd_t cmd,
	input wire sfd_sts_t sts
);

	typedef enum logic [2:0] {
		HUNT,
		GOT_AA,
		GOT_AF,
		GOT_FUNC,
		PAYLOAD,
		CHECK,
		EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic accept;

	assign in_ready = (state_q != EMIT);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.fixed_slot = SLOT_HDR1;
		state_d = state_q;
		if (state_q == EMIT) begin
			cmd.read = !out_valid_q || out_ready;
			if (cmd.read && sts.read_last) begin
				state_d = HUNT;
			end
		end else if (accept) begin
			// Any byte that breaks the pattern is dropped and hunting restarts.
			state_d = HUNT;
			case (state_q)
				HUNT: begin
					if (sts.hdr1) begin
						cmd.store = 1'b1;
						state_d = GOT_AA;
					end
				end
				GOT_AA: begin
					if (sts.hdr2) begin
						cmd.store = 1'b1;
						cmd.fixed_slot = SLOT_HDR2;
						state_d = GOT_AF;
					end
				end
				GOT_AF: begin
					if (sts.func_ok) begin
						cmd.store = 1'b1;
						cmd.fixed_slot = SLOT_FUNC;
						state_d = GOT_FUNC;
					end
				end
				GOT_FUNC: begin
					if (sts.len_ok) begin
						cmd.store = 1'b1;
						cmd.fixed_slot = SLOT_LEN;
						cmd.load_len = 1'b1;
						state_d = PAYLOAD;
					end
				end
				PAYLOAD: begin
					if (sts.rem_nonzero) begin
						cmd.store = 1'b1;
						cmd.payload_slot = 1'b1;
						cmd.step_payload = 1'b1;
						state_d = sts.rem_one ? CHECK : PAYLOAD;
					end
				end
				CHECK: begin
					cmd.store = 1'b1;
					cmd.payload_slot = 1'b1;
					cmd.start_emit = 1'b1;
					state_d = EMIT;
				end
				default: begin
					state_d = HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HUNT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.read) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/sfd_dp.sv
// Datapath of the serial frame deframer: limit register, byte checks,
// payload counters, frame store and the registered output byte. Uses sfd_pkg.
`default_nettype none

module sfd_dp
	import sfd_pkg::*;
#(
	parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata,
	input wire logic [7:0] rx_byte,
	input wire sfd_cmd_t cmd,
	output sfd_sts_t sts,
	output logic [7:0] frame_byte,
	output logic frame_last
);

	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int LIMIT_CAP = (FRAME_DEPTH - 5 < RESULT_CAP - 5) ?
		(FRAME_DEPTH - 5) : (RESULT_CAP - 5);

	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] eff_limit;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] last_addr_q;
	logic [7:0] mem [FRAME_DEPTH];
	logic [7:0] rd_data_q;
	logic rd_last_q;

	// The limit saturates so that a full frame always fits the store.
	assign eff_limit = (limit_q > CNT_W'(LIMIT_CAP)) ? CNT_W'(LIMIT_CAP) : limit_q;

	always_comb begin
		if (cmd.payload_slot) begin
			wr_addr = AW'({1'b0, cnt_q} + 7'd4);
		end else begin
			wr_addr = AW'(cmd.fixed_slot);
		end
	end

	assign sts.hdr1 = (rx_byte == HDR_FIRST);
	assign sts.hdr2 = (rx_byte == HDR_SECOND);
	assign sts.func_ok = (rx_byte != 8'd0) && (rx_byte < FUNC_END);
	assign sts.len_ok = (rx_byte <= {2'b00, eff_limit});
	assign sts.rem_nonzero = (rem_q != '0);
	assign sts.rem_one = (rem_q == CNT_W'(1));
	assign sts.read_last = (rd_addr_q == last_addr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			rem_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.load_len) begin
				rem_q <= rx_byte[CNT_W-1:0];
				cnt_q <= '0;
			end else if (cmd.step_payload) begin
				rem_q <= rem_q - CNT_W'(1);
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[wr_addr] <= rx_byte;
		end
	end

	// The check byte's address is also the frame's last read address.
	always_ff @(posedge clk) begin
		if (cmd.start_emit) begin
			rd_addr_q <= '0;
			last_addr_q <= wr_addr;
		end else if (cmd.read) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (cmd.read) begin
			rd_data_q <= mem[rd_addr_q];
			rd_last_q <= sts.read_last;
		end
	end

	assign frame_byte = rd_data_q;
	assign frame_last = rd_last_q;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_deframer: drives received bytes, predicts the frames it emits.
// Depends on sfd_pkg, the rx_byte_if and frame_byte_if interfaces, and the design top level.

module tb;
	import sfd_pkg::*;

	localparam int LEN_CAP = (FRAME_DEPTH_DEF < RESULT_CAP ? FRAME_DEPTH_DEF : RESULT_CAP) - 5;
	localparam int QUIET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 180;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_GOT_AA = 3'd1,
		PH_GOT_AF = 3'd2,
		PH_GOT_FUNC = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK = 3'd5
	} hunt_phase_t;

	typedef struct {
		logic [7:0] data;
		logic last;
	} frame_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	rx_byte_if rx_ch();
	frame_byte_if fr_ch();

	serial_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx(rx_ch),
		.frame(fr_ch)
	);

	// Shadow copy of the deframer state.
	hunt_phase_t phase_q;
	logic [CNT_W-1:0] len_limit;
	logic [CNT_W-1:0] bytes_left;
	logic [CNT_W-1:0] bytes_seen;
	logic [7:0] frame_copy [FRAME_DEPTH_DEF];

	frame_beat_t owed_beats[$];
	int errors;
	bit stall_en;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [CNT_W-1:0] usable_limit();
		return (int'(len_limit) > LEN_CAP) ? CNT_W'(LEN_CAP) : len_limit;
	endfunction

	task automatic track_rx_byte(input logic [7:0] b);
		int total;
		if (phase_q == PH_HUNT && b == HDR_FIRST) begin
			frame_copy[SLOT_HDR1] = b;
			phase_q = PH_GOT_AA;
		end else if (phase_q == PH_GOT_AA && b == HDR_SECOND) begin
			frame_copy[SLOT_HDR2] = b;
			phase_q = PH_GOT_AF;
		end else if (phase_q == PH_GOT_AF && b != 8'h00 && b < FUNC_END) begin
			frame_copy[SLOT_FUNC] = b;
			phase_q = PH_GOT_FUNC;
		end else if (phase_q == PH_GOT_FUNC && b <= {2'b00, usable_limit()}) begin
			frame_copy[SLOT_LEN] = b;
			bytes_left = b[CNT_W-1:0];
			bytes_seen = '0;
			phase_q = PH_PAYLOAD;
		end else if (phase_q == PH_PAYLOAD && bytes_left != 0) begin
			frame_copy[4 + int'(bytes_seen)] = b;
			bytes_seen = bytes_seen + 1'b1;
			bytes_left = bytes_left - 1'b1;
			if (bytes_left == 0)
				phase_q = PH_CHECK;
		end else if (phase_q == PH_CHECK) begin
			frame_copy[4 + int'(bytes_seen)] = b;
			total = int'(bytes_seen) + 5;
			for (int i = 0; i < total; i++)
				owed_beats.push_back('{data: frame_copy[i], last: (i == total - 1)});
			phase_q = PH_HUNT;
		end else begin
			// A zero length lands here too: the byte after it is dropped.
			phase_q = PH_HUNT;
		end
	endtask

	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && fr_ch.valid && fr_ch.ready) begin
			if (owed_beats.size() == 0) begin
				$error("frame_byte: expected none, got %02h", fr_ch.frame_byte);
				errors++;
			end else begin
				want = owed_beats.pop_front();
				if (fr_ch.frame_byte !== want.data) begin
					$error("frame_byte: expected %02h, got %02h", want.data, fr_ch.frame_byte);
					errors++;
				end
				if (fr_ch.frame_last !== want.last) begin
					$error("frame_last: expected %0b, got %0b", want.last, fr_ch.frame_last);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		fr_ch.ready <= !(stall_en && $urandom_range(99) < 29);

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_byte(input logic [7:0] b);
		while (stall_en && $urandom_range(99) < 29) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		track_rx_byte(b);
		@(negedge clk);
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// Header, function, length, random payload and check byte; one byte may be spoiled.
	task automatic send_frame(input logic [7:0] func, input int len, input int spoil_at);
		logic [7:0] seq[$];
		seq = {HDR_FIRST, HDR_SECOND, func, 8'(len)};
		repeat (len + 1)
			seq.push_back(8'($urandom));
		if (spoil_at >= 0 && spoil_at < seq.size())
			seq[spoil_at] = 8'($urandom);
		send_seq(seq);
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (owed_beats.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		len_limit = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_basic_frames();
		logic [7:0] seq[$];
		seq = {HDR_FIRST, HDR_SECOND, 8'h01, 8'h01, 8'h00, 8'hFF,
			HDR_FIRST, HDR_SECOND, 8'hF0, 8'h02, 8'hFF, 8'h80, 8'h00};
		send_seq(seq);
		wait_drained();
	endtask

	task automatic test_broken_patterns();
		logic [7:0] seq[$];
		// A repeated 0xAA is dropped rather than taken as a fresh header, so the
		// 0xAF after it is dropped too. Then bad function codes and a zero length.
		seq = {HDR_FIRST, HDR_FIRST, HDR_SECOND,
			HDR_FIRST, HDR_SECOND, 8'h00,
			HDR_FIRST, HDR_SECOND, FUNC_END,
			HDR_FIRST, HDR_SECOND, 8'h33, 8'h00, 8'h5A};
		send_seq(seq);
		wait_drained();
	endtask

	task automatic test_limit_extremes();
		logic [7:0] seq[$];
		write_limit(6'd0);
		seq = {HDR_FIRST, HDR_SECOND, 8'h01, 8'h00, 8'hC3,
			HDR_FIRST, HDR_SECOND, 8'h01, 8'h01, 8'h11, 8'h22};
		send_seq(seq);
		wait_drained();
		// Values above the store capacity saturate, so the largest frame still fits.
		write_limit(6'd63);
		send_frame(8'h02, LEN_CAP, -1);
		seq = {HDR_FIRST, HDR_SECOND, 8'h02, 8'(LEN_CAP + 1), 8'h44};
		send_seq(seq);
		wait_drained();
		write_limit(6'd1);
		send_frame(8'h03, 1, -1);
		seq = {HDR_FIRST, HDR_SECOND, 8'h03, 8'h02, 8'h99};
		send_seq(seq);
		wait_drained();
	endtask

	task automatic test_limit_at_length();
		logic [7:0] seq[$];
		// The limit in force when the length byte arrives is the one that counts.
		write_limit(6'd1);
		seq = {HDR_FIRST, HDR_SECOND, 8'h07};
		send_seq(seq);
		wait_drained();
		write_limit(6'd5);
		seq = {8'h05, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'hE7};
		send_seq(seq);
		wait_drained();
	endtask

	task automatic run_random_chunk(input int target);
		int done;
		int pick;
		int lim;
		int len;
		int junk;
		logic [7:0] func;
		logic [7:0] seq[$];
		done = 0;
		while (done < target) begin
			pick = $urandom_range(99);
			lim = int'(usable_limit());
			func = 8'($urandom_range(1, 240));
			if (lim == 0)
				len = 0;
			else if ($urandom_range(9) == 0)
				len = $urandom_range(0, lim);
			else
				len = $urandom_range(1, (lim < 8) ? lim : 8);
			if (pick < 70) begin
				send_frame(func, len, -1);
				done += len + 5;
			end else if (pick < 80) begin
				send_frame(func, len, $urandom_range(0, len + 4));
				done += len + 5;
			end else if (pick < 88) begin
				seq = {HDR_FIRST, HDR_SECOND, func, 8'($urandom_range(lim + 1, 255)),
					8'($urandom)};
				send_seq(seq);
				done += 5;
			end else if (pick < 94) begin
				func = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(241, 255));
				seq = {HDR_FIRST, HDR_SECOND, func, 8'($urandom)};
				send_seq(seq);
				done += 4;
			end else begin
				junk = $urandom_range(1, 6);
				repeat (junk)
					send_byte(8'($urandom));
				done += junk;
			end
		end
		wait_drained();
	endtask

	task automatic test_random_traffic();
		write_limit(LIMIT_RESET);
		run_random_chunk(RANDOM_ITEMS / 4);
		stall_en = 1'b0;
		write_limit(6'($urandom_range(1, 63)));
		run_random_chunk(RANDOM_ITEMS / 4);
		stall_en = 1'b1;
		write_limit(6'd63);
		run_random_chunk(RANDOM_ITEMS / 4);
		write_limit(6'($urandom_range(2, 20)));
		run_random_chunk(RANDOM_ITEMS / 4);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		fr_ch.ready = 1'b0;
		stall_en = 1'b1;
		errors = 0;
		phase_q = PH_HUNT;
		len_limit = LIMIT_RESET;
		bytes_left = '0;
		bytes_seen = '0;
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_frames();
		test_broken_patterns();
		test_limit_extremes();
		test_limit_at_length();
		test_random_traffic();

		repeat (20)
			@(posedge clk);
		if (owed_beats.size() != 0) begin
			$error("frame_byte: expected %02h, got nothing", owed_beats[0].data);
			errors++;
		end
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
